// ----- design/rdp_pkg.sv -----
// Shared constants, types and helper functions of the polyline simplifier.
package rdp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MUL_W      = 2 * DIFF_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SP_W       = MUL_W + 1;
    localparam int EPS_W      = 41;
    localparam int PASS_LIMIT = 3;
    localparam int Q_DEPTH    = 64;
    localparam int Q_IDX_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = Q_IDX_W + 1;
    localparam int MCNT_W     = $clog2(MUL_W);

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } span_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        span_t data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic  empty;
        logic  full;
        span_t front;
    } fifo_stat_t;

    // magnitude of a coordinate difference, widened to the multiplier operand
    function automatic logic [MUL_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
        logic signed [MUL_W-1:0] e;
        e = MUL_W'(d);
        return e[MUL_W-1] ? MUL_W'(-e) : MUL_W'(e);
    endfunction

    // apply a sign to a small product magnitude
    function automatic logic signed [SP_W-1:0] signed_of(input logic [PROD_W-1:0] p,
                                                         input logic neg);
        logic signed [SP_W-1:0] s;
        s = signed'(p[SP_W-1:0]);
        return neg ? -s : s;
    endfunction

endpackage

// ----- design/rdp_mul.sv -----
// Shift-add unsigned multiplier, one operand bit per cycle.
module rdp_mul
    import rdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] p
);

    logic [MUL_W-1:0]  a_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [MUL_W:0]    sum;

    assign sum  = {1'b0, prod_reg[PROD_W-1:MUL_W]} + {1'b0, (prod_reg[0] ? a_reg : '0)};
    assign done = done_reg;
    assign p    = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == MCNT_W'(MUL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_W{1'b0}}, b};
        end
        else if (run_reg)
        begin
            prod_reg <= {sum, prod_reg[MUL_W-1:1]};
        end
    end

endmodule

// ----- design/rdp_span_fifo.sv -----
// Span queue: first-in first-out memory of index pairs.
module rdp_span_fifo
    import rdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_ctrl_t ctrl,
    output fifo_stat_t stat
);

    span_t                q_mem [Q_DEPTH];
    span_t                front_reg;
    logic [Q_IDX_W-1:0]   head_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_IDX_W-1:0]   tail;
    logic                 do_push;
    logic                 do_pop;

    assign tail    = head_reg + count_reg[Q_IDX_W-1:0];
    assign do_push = ctrl.push && !stat.full;
    assign do_pop  = ctrl.pop && !stat.empty;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.front = front_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[tail] <= ctrl.data;
        if (do_pop)
            front_reg <= q_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_pop)
                head_reg <= head_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- design/polyline_rdp_simplifier_core.sv -----
// Top level: point store, span sequencer and kept-point emission.
//
// Usage: raise start with point_x, point_y and is_last; a point is taken
// at a clock edge where start is high and busy is low. Loading accepts
// points back to back and busy stays low between points. The point with
// is_last set ends the polyline: busy rises and the block simplifies,
// then presents each kept point in input order for one cycle with
// result_valid high; last_kept marks the final one, overflowed is high on
// every result of a polyline that lost points beyond the 64-entry store.
// After is_last, each inner point of a span costs five products on the
// shared shift-add multiplier plus store reads, each span its own setup
// products; emission scans every stored point. Polylines of three or fewer
// points skip the search. The receiver cannot stall; results are strobes.
// cfg_valid/cfg_ready write eps_squared (reset 65536); cfg_ready is always
// high and writes belong to idle time. Reset empties the store and queue.
module polyline_rdp_simplifier_core
    import rdp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic                      is_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [EPS_W-1:0]          cfg_data,
    output logic                      result_valid,
    output logic signed [COORD_W-1:0] kept_x,
    output logic signed [COORD_W-1:0] kept_y,
    output logic                      last_kept,
    output logic                      overflowed
);

    typedef enum logic [4:0] {
        S_IDLE, S_POP, S_RDA, S_RDB, S_SPAN, S_C2A, S_C2B, S_EPSD,
        S_RDP, S_PCAP, S_M1, S_M2, S_M3, S_M4, S_M5, S_NEXT,
        S_PUSH1, S_PUSH2, S_E_SCAN, S_E_GET, S_E_END
    } state_t;

    state_t                     state_reg;
    logic                       issued_reg;
    logic [EPS_W-1:0]           eps_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           n_reg;
    logic                       ovf_reg;
    logic [MAX_POINTS-1:0]      keep_reg;
    logic [IDX_W-1:0]           lo_reg, hi_reg, best_reg, i_reg;
    logic [CNT_W-1:0]           e_reg;
    logic signed [COORD_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DIFF_W-1:0]   vx_reg, vy_reg, wx_reg, wy_reg, ux_reg, uy_reg;
    logic signed [DIFF_W-1:0]   op3a_reg, op3b_reg, op4a_reg, op4b_reg;
    logic                       cross_reg;
    logic signed [SP_W-1:0]     t_reg, r_reg;
    logic [MUL_W-1:0]           c2_reg, den_reg;
    logic [PROD_W-1:0]          epsden_reg, nmax_reg;
    logic                       pend_valid_reg;
    logic signed [COORD_W-1:0]  pend_x_reg, pend_y_reg;
    logic                       result_valid_reg, last_kept_reg, overflowed_reg;
    logic signed [COORD_W-1:0]  kept_x_reg, kept_y_reg;

    logic [2*COORD_W-1:0]       store_mem [MAX_POINTS];
    logic [2*COORD_W-1:0]       store_rd_reg;
    logic [IDX_W-1:0]           mem_addr;
    logic                       mem_we;
    logic signed [COORD_W-1:0]  rd_x, rd_y;

    logic                       accept, store_wr;
    logic [CNT_W-1:0]           n_load;
    logic                       is_mul, mul_start, mul_done;
    logic [MUL_W-1:0]           mul_a, mul_b, r_mag;
    logic [PROD_W-1:0]          mul_p;
    logic signed [DIFF_W-1:0]   pair_a, pair_b;
    logic signed [SP_W-1:0]     sprod, acc_sum, acc_diff;
    logic [CNT_W-1:0]           i_nx;
    fifo_ctrl_t                 fctrl;
    fifo_stat_t                 fstat;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign kept_x       = kept_x_reg;
    assign kept_y       = kept_y_reg;
    assign last_kept    = last_kept_reg;
    assign overflowed   = overflowed_reg;

    assign accept   = start && (state_reg == S_IDLE);
    assign store_wr = accept && (count_reg < CNT_W'(MAX_POINTS));
    assign n_load   = count_reg + CNT_W'(store_wr);
    assign mem_we   = store_wr;
    assign rd_x     = signed'(store_rd_reg[2*COORD_W-1:COORD_W]);
    assign rd_y     = signed'(store_rd_reg[COORD_W-1:0]);
    assign i_nx     = CNT_W'(i_reg) + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= {point_x, point_y};
        store_rd_reg <= store_mem[mem_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   mem_addr = count_reg[IDX_W-1:0];
            S_RDA:    mem_addr = fstat.front.lo;
            S_RDB:    mem_addr = hi_reg;
            S_RDP:    mem_addr = i_reg;
            S_E_SCAN: mem_addr = e_reg[IDX_W-1:0];
            default:  mem_addr = '0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_C2B:   begin pair_a = vy_reg;   pair_b = vy_reg;   end
            S_M1:    begin pair_a = wx_reg;   pair_b = vx_reg;   end
            S_M2:    begin pair_a = wy_reg;   pair_b = vy_reg;   end
            S_M3:    begin pair_a = op3a_reg; pair_b = op3b_reg; end
            S_M4:    begin pair_a = op4a_reg; pair_b = op4b_reg; end
            default: begin pair_a = vx_reg;   pair_b = vx_reg;   end
        endcase
    end

    assign r_mag = r_reg[SP_W-1] ? MUL_W'(-r_reg) : MUL_W'(r_reg);

    always_comb
    begin
        unique case (state_reg)
            S_EPSD:
            begin
                mul_a = MUL_W'(eps_reg);
                mul_b = den_reg;
            end
            S_M5:
            begin
                mul_a = r_mag;
                mul_b = cross_reg ? r_mag : den_reg;
            end
            default:
            begin
                mul_a = diff_mag(pair_a);
                mul_b = diff_mag(pair_b);
            end
        endcase
    end

    assign is_mul = (state_reg == S_C2A) || (state_reg == S_C2B) || (state_reg == S_EPSD)
                 || (state_reg == S_M1) || (state_reg == S_M2) || (state_reg == S_M3)
                 || (state_reg == S_M4) || (state_reg == S_M5);
    assign mul_start = is_mul && !issued_reg;
    assign sprod     = signed_of(mul_p, pair_a[DIFF_W-1] ^ pair_b[DIFF_W-1]);
    assign acc_sum   = t_reg + sprod;
    assign acc_diff  = t_reg - sprod;

    always_comb
    begin
        fctrl.push = 1'b0;
        fctrl.pop  = (state_reg == S_POP);
        fctrl.data = '{lo: best_reg, hi: hi_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                fctrl.push = accept && is_last && (n_load > CNT_W'(PASS_LIMIT));
                fctrl.data = '{lo: '0, hi: IDX_W'(n_load - 1'b1)};
            end
            S_PUSH1:
            begin
                fctrl.push = 1'b1;
                fctrl.data = '{lo: lo_reg, hi: best_reg};
            end
            S_PUSH2:
            begin
                fctrl.push = 1'b1;
            end
            default:
            begin
                fctrl.push = 1'b0;
            end
        endcase
    end

    rdp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    rdp_span_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fctrl),
        .stat  (fstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issued_reg       <= 1'b0;
            eps_reg          <= EPS_W'(65536);
            count_reg        <= '0;
            n_reg            <= '0;
            ovf_reg          <= 1'b0;
            keep_reg         <= '0;
            e_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_valid)
                eps_reg <= cfg_data;
            if (mul_start)
                issued_reg <= 1'b1;
            else if (mul_done)
                issued_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= n_load;
                        if (!store_wr)
                            ovf_reg <= 1'b1;
                        if (is_last)
                        begin
                            n_reg <= n_load;
                            if (n_load <= CNT_W'(PASS_LIMIT))
                            begin
                                for (int k = 0; k < MAX_POINTS; k++)
                                    keep_reg[k] <= (CNT_W'(k) < n_load);
                                e_reg          <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= S_E_SCAN;
                            end
                            else
                            begin
                                state_reg <= S_POP;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    if (fstat.empty)
                    begin
                        e_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_E_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                begin
                    lo_reg    <= fstat.front.lo;
                    hi_reg    <= fstat.front.hi;
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    ax_reg    <= rd_x;
                    ay_reg    <= rd_y;
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    bx_reg <= rd_x;
                    by_reg <= rd_y;
                    vx_reg <= DIFF_W'(ax_reg) - DIFF_W'(rd_x);
                    vy_reg <= DIFF_W'(ay_reg) - DIFF_W'(rd_y);
                    // span without inner points keeps both ends
                    if (CNT_W'(hi_reg) <= CNT_W'(lo_reg) + 1'b1)
                    begin
                        keep_reg[lo_reg] <= 1'b1;
                        keep_reg[hi_reg] <= 1'b1;
                        state_reg        <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_C2A;
                    end
                end
                S_C2A:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= sprod;
                        state_reg <= S_C2B;
                    end
                end
                S_C2B:
                begin
                    if (mul_done)
                    begin
                        c2_reg    <= acc_sum[MUL_W-1:0];
                        den_reg   <= (acc_sum == '0) ? MUL_W'(1) : acc_sum[MUL_W-1:0];
                        state_reg <= S_EPSD;
                    end
                end
                S_EPSD:
                begin
                    if (mul_done)
                    begin
                        epsden_reg <= mul_p;
                        nmax_reg   <= '0;
                        best_reg   <= '0;
                        i_reg      <= lo_reg + 1'b1;
                        state_reg  <= S_RDP;
                    end
                end
                S_RDP:
                begin
                    state_reg <= S_PCAP;
                end
                S_PCAP:
                begin
                    wx_reg    <= DIFF_W'(rd_x) - DIFF_W'(bx_reg);
                    wy_reg    <= DIFF_W'(rd_y) - DIFF_W'(by_reg);
                    ux_reg    <= DIFF_W'(rd_x) - DIFF_W'(ax_reg);
                    uy_reg    <= DIFF_W'(rd_y) - DIFF_W'(ay_reg);
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= sprod;
                        state_reg <= S_M2;
                    end
                end
                S_M2:
                begin
                    if (mul_done)
                    begin
                        // acc_sum is the projection dot product c1
                        if (acc_sum[SP_W-1])
                        begin
                            op3a_reg  <= wx_reg; op3b_reg <= wx_reg;
                            op4a_reg  <= wy_reg; op4b_reg <= wy_reg;
                            cross_reg <= 1'b0;
                        end
                        else if ($unsigned(acc_sum) >= SP_W'(c2_reg))
                        begin
                            op3a_reg  <= ux_reg; op3b_reg <= ux_reg;
                            op4a_reg  <= uy_reg; op4b_reg <= uy_reg;
                            cross_reg <= 1'b0;
                        end
                        else
                        begin
                            op3a_reg  <= vx_reg; op3b_reg <= wy_reg;
                            op4a_reg  <= vy_reg; op4b_reg <= wx_reg;
                            cross_reg <= 1'b1;
                        end
                        state_reg <= S_M3;
                    end
                end
                S_M3:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= sprod;
                        state_reg <= S_M4;
                    end
                end
                S_M4:
                begin
                    if (mul_done)
                    begin
                        r_reg     <= cross_reg ? acc_diff : acc_sum;
                        state_reg <= S_M5;
                    end
                end
                S_M5:
                begin
                    if (mul_done)
                    begin
                        // strict compare keeps the first of equal maxima
                        if (mul_p > nmax_reg)
                        begin
                            nmax_reg <= mul_p;
                            best_reg <= i_reg;
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (i_nx < CNT_W'(hi_reg))
                    begin
                        i_reg     <= i_nx[IDX_W-1:0];
                        state_reg <= S_RDP;
                    end
                    else if (nmax_reg > epsden_reg)
                    begin
                        state_reg <= S_PUSH1;
                    end
                    else
                    begin
                        keep_reg[lo_reg] <= 1'b1;
                        keep_reg[hi_reg] <= 1'b1;
                        state_reg        <= S_POP;
                    end
                end
                S_PUSH1:
                begin
                    state_reg <= S_PUSH2;
                end
                S_PUSH2:
                begin
                    state_reg <= S_POP;
                end
                S_E_SCAN:
                begin
                    if (e_reg == n_reg)
                        state_reg <= S_E_END;
                    else if (keep_reg[e_reg[IDX_W-1:0]])
                        state_reg <= S_E_GET;
                    else
                        e_reg <= e_reg + 1'b1;
                end
                S_E_GET:
                begin
                    // one point held back so the final one can carry last_kept
                    if (pend_valid_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        kept_x_reg       <= pend_x_reg;
                        kept_y_reg       <= pend_y_reg;
                        last_kept_reg    <= 1'b0;
                        overflowed_reg   <= ovf_reg;
                    end
                    pend_x_reg     <= rd_x;
                    pend_y_reg     <= rd_y;
                    pend_valid_reg <= 1'b1;
                    e_reg          <= e_reg + 1'b1;
                    state_reg      <= S_E_SCAN;
                end
                S_E_END:
                begin
                    result_valid_reg <= pend_valid_reg;
                    kept_x_reg       <= pend_x_reg;
                    kept_y_reg       <= pend_y_reg;
                    last_kept_reg    <= 1'b1;
                    overflowed_reg   <= ovf_reg;
                    pend_valid_reg   <= 1'b0;
                    keep_reg         <= '0;
                    count_reg        <= '0;
                    ovf_reg          <= 1'b0;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
